// ===== rtl/lcdseq_pkg.sv =====
package lcdseq_pkg;

    // request codes
    localparam logic [2:0] ACT_INIT      = 3'd0;
    localparam logic [2:0] ACT_CLEAR     = 3'd1;
    localparam logic [2:0] ACT_HOME      = 3'd2;
    localparam logic [2:0] ACT_DISP_CTRL = 3'd3;
    localparam logic [2:0] ACT_SET_POS   = 3'd4;
    localparam logic [2:0] ACT_STR_START = 3'd5;
    localparam logic [2:0] ACT_STR_CHAR  = 3'd6;

    // configuration register indexes
    localparam logic [2:0] CFG_FULL_BUS    = 3'd0;
    localparam logic [2:0] CFG_TALL_FONT   = 3'd1;
    localparam logic [2:0] CFG_TWO_ROWS    = 3'd2;
    localparam logic [2:0] CFG_ROW_LEN_16  = 3'd3;
    localparam logic [2:0] CFG_CURSOR_ON   = 3'd4;
    localparam logic [2:0] CFG_CURSOR_BLNK = 3'd5;

    // instruction bytes and bits
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_HOME       = 8'h02;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
    localparam logic [7:0] BIT_BLINK      = 8'h01;
    localparam logic [7:0] BIT_CURSOR     = 8'h02;
    localparam logic [7:0] BIT_TALL       = 8'h04;
    localparam logic [7:0] BIT_TWO_ROWS   = 8'h08;
    localparam logic [7:0] BIT_EIGHT_BIT  = 8'h10;
    localparam logic [7:0] CMD_FUNC_SET   = 8'h20;
    localparam logic [7:0] BIT_ROW_TWO    = 8'h40;
    localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;

    // timing in microseconds
    localparam logic [11:0] DELAY_LONG_US   = 12'd1600;
    localparam logic [11:0] DELAY_SHORT_US  = 12'd45;
    localparam logic [11:0] INIT_IDLE_US    = 12'd40;
    localparam logic [11:0] WAIT_NIBBLE_US  = 12'd1;
    localparam logic [11:0] WAIT_BYTE_US    = 12'd1000;
    localparam logic [9:0]  EN_NIBBLE_US    = 10'd1;
    localparam logic [9:0]  EN_BYTE_US      = 10'd1000;

    // init sequence steps
    localparam logic [2:0] INIT_STEP_IDLE  = 3'd0;
    localparam logic [2:0] INIT_STEP_FS1   = 3'd1;
    localparam logic [2:0] INIT_STEP_FS2   = 3'd2;
    localparam logic [2:0] INIT_STEP_DISP  = 3'd3;
    localparam logic [2:0] INIT_STEP_CLEAR = 3'd4;
    localparam logic [2:0] INIT_STEP_ENTRY = 3'd5;
    localparam logic [2:0] INIT_STEP_HOME  = 3'd6;

    localparam int unsigned COUNT_W     = 6;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic full_bus;
        logic tall_font;
        logic two_rows;
        logic row_len_16;
        logic cursor_on;
        logic cursor_blink;
    } t_cfg;

    // init: a_byte carries function set, b_byte display control
    typedef struct packed {
        logic       is_init;
        logic       has_a;
        logic [7:0] a_byte;
        logic       has_b;
        logic       b_rs;
        logic [7:0] b_byte;
        logic       b_long;
    } t_job;

    typedef struct packed {
        logic        rs;
        logic        strobe;
        logic [7:0]  bus;
        logic [9:0]  en_us;
        logic [11:0] wait_us;
        logic        last;
    } t_xfer;

endpackage

// ===== rtl/lcdseq_front.sv =====
module lcdseq_front #(
    parameter int MAX_STRING_CHARS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lcdseq_pkg::t_cfg    i_cfg,
    input  logic                i_accept,
    input  logic [2:0]          i_action,
    input  logic [7:0]          i_position,
    input  logic [7:0]          i_character,
    output logic                o_push,
    output lcdseq_pkg::t_job    o_job
);

    localparam logic [lcdseq_pkg::COUNT_W-1:0] MaxChars =
        lcdseq_pkg::COUNT_W'(MAX_STRING_CHARS);

    logic [lcdseq_pkg::COUNT_W-1:0] r_count;
    logic [lcdseq_pkg::COUNT_W-1:0] n_count;
    logic [4:0] row_len;
    logic [5:0] screen_len;
    logic       pos_ok;
    logic [7:0] pos_byte;
    logic [7:0] fs_byte;
    logic [7:0] dc_byte;
    logic       emits;

    always_comb begin
        row_len    = i_cfg.row_len_16 ? 5'd16 : 5'd8;
        screen_len = i_cfg.two_rows ? {row_len, 1'b0} : {1'b0, row_len};
        pos_ok     = i_position < {2'b00, screen_len};
        if (i_position >= {3'b000, row_len}) begin
            pos_byte = lcdseq_pkg::CMD_SET_DDRAM | lcdseq_pkg::BIT_ROW_TWO
                       | (i_position - {3'b000, row_len});
        end else begin
            pos_byte = lcdseq_pkg::CMD_SET_DDRAM | i_position;
        end

        fs_byte = lcdseq_pkg::CMD_FUNC_SET;
        if (i_cfg.full_bus)  fs_byte = fs_byte | lcdseq_pkg::BIT_EIGHT_BIT;
        if (i_cfg.tall_font) fs_byte = fs_byte | lcdseq_pkg::BIT_TALL;
        if (i_cfg.two_rows)  fs_byte = fs_byte | lcdseq_pkg::BIT_TWO_ROWS;

        dc_byte = lcdseq_pkg::CMD_DISP_ON;
        if (i_cfg.cursor_on) begin
            dc_byte = dc_byte | lcdseq_pkg::BIT_CURSOR;
            if (i_cfg.cursor_blink) dc_byte = dc_byte | lcdseq_pkg::BIT_BLINK;
        end
    end

    always_comb begin
        o_job   = '0;
        emits   = 1'b0;
        n_count = r_count;
        case (i_action)
            lcdseq_pkg::ACT_INIT: begin
                emits        = 1'b1;
                o_job.is_init = 1'b1;
                o_job.has_a  = 1'b1;
                o_job.a_byte = fs_byte;
                o_job.has_b  = 1'b1;
                o_job.b_byte = dc_byte;
            end
            lcdseq_pkg::ACT_CLEAR: begin
                emits        = 1'b1;
                o_job.has_b  = 1'b1;
                o_job.b_byte = lcdseq_pkg::CMD_CLEAR;
                o_job.b_long = 1'b1;
            end
            lcdseq_pkg::ACT_HOME: begin
                emits        = 1'b1;
                o_job.has_b  = 1'b1;
                o_job.b_byte = lcdseq_pkg::CMD_HOME;
                o_job.b_long = 1'b1;
            end
            lcdseq_pkg::ACT_DISP_CTRL: begin
                emits        = 1'b1;
                o_job.has_b  = 1'b1;
                o_job.b_byte = dc_byte;
            end
            lcdseq_pkg::ACT_SET_POS, lcdseq_pkg::ACT_STR_START: begin
                emits        = pos_ok;
                o_job.has_a  = 1'b1;
                o_job.a_byte = pos_byte;
                if (i_action == lcdseq_pkg::ACT_STR_START) n_count = '0;
            end
            lcdseq_pkg::ACT_STR_CHAR: begin
                if (r_count < MaxChars) begin
                    if (i_character == 8'h00) begin
                        n_count = MaxChars;
                    end else begin
                        // wrap onto row two once row one is full
                        emits        = 1'b1;
                        o_job.has_a  = i_cfg.two_rows
                                       && (r_count == {1'b0, row_len});
                        o_job.a_byte = lcdseq_pkg::CMD_SET_DDRAM
                                       | lcdseq_pkg::BIT_ROW_TWO;
                        o_job.has_b  = 1'b1;
                        o_job.b_rs   = 1'b1;
                        o_job.b_byte = i_character;
                        n_count      = r_count + 1'b1;
                    end
                end
            end
            default: begin
                emits = 1'b0;
            end
        endcase
    end

    assign o_push = i_accept && emits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/lcdseq_queue.sv =====
module lcdseq_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lcdseq_pkg::t_job i_data,
    input  logic             i_pop,
    output lcdseq_pkg::t_job o_data,
    output logic             o_not_empty,
    output logic             o_full
);

    localparam int unsigned Depth = lcdseq_pkg::QUEUE_DEPTH;
    localparam int unsigned PtrW  = lcdseq_pkg::QUEUE_PTR_W;
    localparam int unsigned CntW  = lcdseq_pkg::QUEUE_CNT_W;
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    lcdseq_pkg::t_job r_mem [Depth];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;

    assign o_data      = r_mem[r_rd_ptr];
    assign o_not_empty = r_count != '0;
    assign o_full      = r_count == FullCnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            if (i_push && !i_pop) r_count <= r_count + 1'b1;
            else if (i_pop && !i_push) r_count <= r_count - 1'b1;
        end
    end

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a push");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue popped while empty");

endmodule

// ===== rtl/lcdseq_back.sv =====
module lcdseq_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lcdseq_pkg::t_cfg  i_cfg,
    input  lcdseq_pkg::t_job  i_job,
    input  logic              i_job_ready,
    output logic              o_pop,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output lcdseq_pkg::t_xfer o_xfer
);

    lcdseq_pkg::t_job  r_job;
    logic              r_busy;
    logic [2:0]        r_step;
    logic              r_nib;
    logic              r_out_valid;
    lcdseq_pkg::t_xfer r_xfer;

    logic              idle_step;
    logic              rs;
    logic [7:0]        byte_val;
    logic              long_delay;
    logic [11:0]       delay;
    logic              last_step;
    logic              byte_done;
    logic              can_load;
    logic              advance;
    logic              finish;
    logic [2:0]        start_step;
    lcdseq_pkg::t_xfer xfer;

    // what the current step sends
    always_comb begin
        idle_step  = 1'b0;
        rs         = 1'b0;
        byte_val   = r_job.a_byte;
        long_delay = 1'b0;
        if (r_job.is_init) begin
            last_step = r_step == lcdseq_pkg::INIT_STEP_HOME;
            case (r_step)
                lcdseq_pkg::INIT_STEP_IDLE:  idle_step = 1'b1;
                lcdseq_pkg::INIT_STEP_FS1,
                lcdseq_pkg::INIT_STEP_FS2:   byte_val = r_job.a_byte;
                lcdseq_pkg::INIT_STEP_DISP:  byte_val = r_job.b_byte;
                lcdseq_pkg::INIT_STEP_CLEAR: begin
                    byte_val   = lcdseq_pkg::CMD_CLEAR;
                    long_delay = 1'b1;
                end
                lcdseq_pkg::INIT_STEP_ENTRY: byte_val = lcdseq_pkg::CMD_ENTRY_MODE;
                lcdseq_pkg::INIT_STEP_HOME: begin
                    byte_val   = lcdseq_pkg::CMD_HOME;
                    long_delay = 1'b1;
                end
                default: idle_step = 1'b1;
            endcase
        end else begin
            last_step = r_step[0] || !r_job.has_b;
            if (r_step[0]) begin
                rs         = r_job.b_rs;
                byte_val   = r_job.b_byte;
                long_delay = r_job.b_long;
            end
        end

        delay     = long_delay ? lcdseq_pkg::DELAY_LONG_US : lcdseq_pkg::DELAY_SHORT_US;
        byte_done = idle_step || i_cfg.full_bus || r_nib;

        xfer.rs     = rs;
        xfer.strobe = !idle_step;
        xfer.last   = last_step && byte_done;
        if (idle_step) begin
            xfer.bus     = 8'h00;
            xfer.en_us   = 10'd0;
            xfer.wait_us = lcdseq_pkg::INIT_IDLE_US;
        end else if (i_cfg.full_bus) begin
            xfer.bus     = byte_val;
            xfer.en_us   = lcdseq_pkg::EN_BYTE_US;
            xfer.wait_us = lcdseq_pkg::WAIT_BYTE_US + delay;
        end else if (!r_nib) begin
            xfer.bus     = {4'h0, byte_val[7:4]};
            xfer.en_us   = lcdseq_pkg::EN_NIBBLE_US;
            xfer.wait_us = lcdseq_pkg::WAIT_NIBBLE_US;
        end else begin
            xfer.bus     = {4'h0, byte_val[3:0]};
            xfer.en_us   = lcdseq_pkg::EN_NIBBLE_US;
            xfer.wait_us = lcdseq_pkg::WAIT_NIBBLE_US + delay;
        end
    end

    assign can_load   = !r_out_valid || !i_out_stall;
    assign advance    = r_busy && can_load;
    assign finish     = advance && xfer.last;
    assign o_pop      = i_job_ready && (!r_busy || finish);
    assign start_step = (i_job.is_init || i_job.has_a) ? 3'd0 : 3'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_nib       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_step <= start_step;
                r_nib  <= 1'b0;
            end else if (finish) begin
                r_busy <= 1'b0;
            end else if (advance) begin
                if (byte_done) begin
                    r_step <= r_step + 1'b1;
                    r_nib  <= 1'b0;
                end else begin
                    r_nib <= 1'b1;
                end
            end
            if (can_load) r_out_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
        if (advance) r_xfer <= xfer;
    end

    assign o_out_valid = r_out_valid;
    assign o_xfer      = r_xfer;

    a_short_job_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_job.is_init) |-> (r_step <= 3'd1))
        else $error("request job ran past its second byte");
    a_nibble_half_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_nib) |-> !i_cfg.full_bus)
        else $error("low nibble phase in eight-bit mode");

endmodule

// ===== rtl/char_lcd_command_sequencer_core.sv =====
// character lcd command sequencer: each host request (init, clear, home, display
// control, set position, string start, string char) becomes the lcd bus words it
// needs, each with rs, a nibble or byte, enable high time and wait time in
// microseconds; the last word of a request carries o_last_transfer. a front end
// takes one request per cycle while the job queue has room, resolves positions
// and the string counter, and drops requests that send nothing; a two-entry job
// queue feeds a back end that sends one bus word per cycle while the output is
// not stalled. a request sends 1 to 13 words (two per byte in four-bit mode, one
// in eight-bit mode, init adds one idle word); the back end's registered output
// sets the sustained rate.
// requests keep being taken while the queue has room, even with a word stalled.
// configuration writes are meant for idle periods only
module char_lcd_command_sequencer_core #(
    parameter int MAX_STRING_CHARS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic        i_cfg_data,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_position,
    input  logic [7:0]  i_character,
    // bus word channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_reg_select,
    output logic        o_strobe_res,
    output logic [7:0]  o_bus_value,
    output logic [9:0]  o_enable_us,
    output logic [11:0] o_wait_us,
    output logic        o_last_transfer
);

    lcdseq_pkg::t_cfg  r_cfg;
    lcdseq_pkg::t_job  front_job;
    lcdseq_pkg::t_job  queue_job;
    lcdseq_pkg::t_xfer back_xfer;
    logic              in_accept;
    logic              push;
    logic              pop;
    logic              queue_not_empty;
    logic              queue_full;

    // configuration registers, unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.full_bus     <= 1'b0;
            r_cfg.tall_font    <= 1'b0;
            r_cfg.two_rows     <= 1'b1;
            r_cfg.row_len_16   <= 1'b1;
            r_cfg.cursor_on    <= 1'b0;
            r_cfg.cursor_blink <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lcdseq_pkg::CFG_FULL_BUS:    r_cfg.full_bus     <= i_cfg_data;
                lcdseq_pkg::CFG_TALL_FONT:   r_cfg.tall_font    <= i_cfg_data;
                lcdseq_pkg::CFG_TWO_ROWS:    r_cfg.two_rows     <= i_cfg_data;
                lcdseq_pkg::CFG_ROW_LEN_16:  r_cfg.row_len_16   <= i_cfg_data;
                lcdseq_pkg::CFG_CURSOR_ON:   r_cfg.cursor_on    <= i_cfg_data;
                lcdseq_pkg::CFG_CURSOR_BLNK: r_cfg.cursor_blink <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the front end only stalls when the job queue is full
    assign o_in_stall = queue_full;
    assign in_accept  = i_in_valid && !queue_full;

    lcdseq_front #(
        .MAX_STRING_CHARS (MAX_STRING_CHARS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (in_accept),
        .i_action    (i_action),
        .i_position  (i_position),
        .i_character (i_character),
        .o_push      (push),
        .o_job       (front_job)
    );

    lcdseq_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      (front_job),
        .i_pop       (pop),
        .o_data      (queue_job),
        .o_not_empty (queue_not_empty),
        .o_full      (queue_full)
    );

    lcdseq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (queue_job),
        .i_job_ready (queue_not_empty),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_xfer      (back_xfer)
    );

    assign o_reg_select    = back_xfer.rs;
    assign o_strobe_res    = back_xfer.strobe;
    assign o_bus_value     = back_xfer.bus;
    assign o_enable_us     = back_xfer.en_us;
    assign o_wait_us       = back_xfer.wait_us;
    assign o_last_transfer = back_xfer.last;

    // a word may only be withdrawn after it was taken
    a_word_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_out_valid) && $past(i_rst_n)) |-> !$past(i_out_stall))
        else $error("bus word dropped while stalled");

endmodule
